@@ hdl/mf3x3_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mf3x3_pkg;

    // Largest supported image side.
    localparam int MAX_SIZE = 32;

    localparam int PIX_W  = 8;
    localparam int SIZE_W = 6;

    // Column index into the line buffer, row counter up to MAX_SIZE + 1.
    localparam int COL_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int ROW_W = $clog2(MAX_SIZE + 2);
    // Compare width for positions against the image side.
    localparam int CMP_W = SIZE_W + 1;

    // Three pixels per column, nine per window.
    localparam int COLSUM_W = PIX_W + 2;
    localparam int SUM_W    = PIX_W + 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    // Reciprocal multipliers: floor((s+3)/6) and floor((s+4)/9) for s <= 9*255.
    localparam int MUL_W      = 12;
    localparam int PROD_W     = SUM_W + MUL_W;
    localparam logic [MUL_W-1:0] DIV6_MUL = 12'd2731;
    localparam int DIV6_SHIFT = 14;
    localparam logic [MUL_W-1:0] DIV9_MUL = 12'd3641;
    localparam int DIV9_SHIFT = 15;

    // One line buffer entry: the previous row and the row before it.
    typedef struct packed {
        logic [PIX_W-1:0] line1;
        logic [PIX_W-1:0] line2;
    } line_pair_t;

endpackage

`default_nettype wire

@@ hdl/mean_filter_3x3_edge_shrink.sv @@
`timescale 1ns / 1ps
`default_nettype none

// 3x3 box mean filter with edge shrink for square images of 8-bit pixels.
// Input channel (in_valid / in_ready / pixel) takes the image in raster order,
// one pixel per beat. Output channel (out_valid / out_ready) carries one
// filtered pixel per beat with row_end on the last pixel of a row and last on
// the final result caused by one input beat. The cfg channel writes the image
// side (0 acts as 1, above MAX_SIZE acts as MAX_SIZE) and restarts the image.
// Throughput: one pixel per cycle unless stalled. A result passes the input
// stage and output register; the beat completing its window is one row plus
// one pixel after its position. The last pixel of an image starts a flush of
// side + 1 further results, one per cycle unless stalled, with in_ready low;
// the single output register sets that pace. A 1x1 image passes every pixel
// straight through. When the receiver stalls, the output register holds its
// beat, one more pixel can still sit in the input stage, then in_ready drops.
// Reset sets the side to 32 and starts a new image; the line buffer is not
// cleared, as only entries written earlier in the image are ever used.
module mean_filter_3x3_edge_shrink (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mf3x3_pkg::SIZE_W-1:0]   cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [mf3x3_pkg::PIX_W-1:0]    pixel,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [mf3x3_pkg::PIX_W-1:0]         mean_value,
    output logic                                row_end,
    output logic                                last
);
    import mf3x3_pkg::*;

    // Configuration and position of the next beat
    logic [SIZE_W-1:0] size_reg;
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0]  col_cnt_reg, col_cnt_next;
    logic              flush_reg, flush_next;

    // Input stage: pixel, line buffer read, position
    logic              s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0]  s1_pix_reg;
    line_pair_t        s1_line_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;

    // Column sums of the two columns left of the current one
    logic [COLSUM_W-1:0] cs1_reg, cs2_reg;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  mean_reg;
    logic              row_end_reg;
    logic              last_reg;

    // Line buffer: one entry per column
    line_pair_t line_mem [MAX_SIZE];

    logic [SIZE_W-1:0] n_eff;
    logic [CMP_W-1:0]  n_x, nm1_x, np1_x;
    logic              n_one;
    logic [CMP_W-1:0]  row_x, col_x, srow, scol;

    logic issue_valid, s1_load, s1_free, s1_go, s1_emit, out_free;
    logic top_in, mid_in, bot_in, col_zero, rows3, cols3, s1_real;
    logic last_flag;

    logic [COLSUM_W-1:0] cs0;
    logic [SUM_W-1:0]    win_sum, sum_p2, sum_p3, sum_p4;
    logic [PROD_W-1:0]   prod6, prod9, quot6, quot9;
    logic [PIX_W-1:0]    mean_calc;

    // Clamp the side to 1..MAX_SIZE
    always_comb
    begin
        if (size_reg == '0)
            n_eff = SIZE_W'(1);
        else if (CMP_W'(size_reg) > CMP_W'(MAX_SIZE))
            n_eff = SIZE_W'(MAX_SIZE);
        else
            n_eff = size_reg;
    end

    assign n_x   = CMP_W'(n_eff);
    assign nm1_x = n_x - CMP_W'(1);
    assign np1_x = n_x + CMP_W'(1);
    assign n_one = (n_x == CMP_W'(1));

    assign row_x = CMP_W'(row_cnt_reg);
    assign col_x = CMP_W'(col_cnt_reg);
    assign srow  = CMP_W'(s1_row_reg);
    assign scol  = CMP_W'(s1_col_reg);

    // Handshake. During a flush the stage issues phantom positions below the
    // image so the last two rows drain through the same path.
    assign cfg_ready   = 1'b1;
    assign out_free    = !out_valid_reg || out_ready;
    assign s1_go       = s1_valid_reg && (!s1_emit || out_free);
    assign s1_free     = !s1_valid_reg || s1_go;
    assign issue_valid = flush_reg || in_valid;
    assign s1_load     = issue_valid && s1_free;
    assign in_ready    = !flush_reg && s1_free;

    // Advance the position counters
    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        flush_next   = flush_reg;
        if (cfg_valid)
        begin
            // Restart the image on any register write
            row_cnt_next = '0;
            col_cnt_next = '0;
            flush_next   = 1'b0;
        end
        else if (s1_load)
        begin
            if (flush_reg)
            begin
                if (row_x == n_x)
                begin
                    if (col_x + CMP_W'(1) >= n_x)
                    begin
                        row_cnt_next = ROW_W'(np1_x);
                        col_cnt_next = '0;
                    end
                    else
                    begin
                        col_cnt_next = COL_W'(col_x + CMP_W'(1));
                    end
                end
                else
                begin
                    // Final phantom issued: start the next image
                    row_cnt_next = '0;
                    col_cnt_next = '0;
                    flush_next   = 1'b0;
                end
            end
            else if (row_x == nm1_x && col_x == nm1_x)
            begin
                col_cnt_next = '0;
                if (n_one)
                begin
                    row_cnt_next = '0;
                end
                else
                begin
                    row_cnt_next = ROW_W'(n_x);
                    flush_next   = 1'b1;
                end
            end
            else if (col_x + CMP_W'(1) >= n_x)
            begin
                col_cnt_next = '0;
                row_cnt_next = ROW_W'(row_x + CMP_W'(1));
            end
            else
            begin
                col_cnt_next = COL_W'(col_x + CMP_W'(1));
            end
        end
    end

    // Window arithmetic on the input stage.
    // A beat at (row, col) with col > 0 completes the window centered at
    // (row-1, col-1); a beat at col 0 completes the right-edge window of the
    // row two above, built from the column sums held from the previous row.
    assign s1_real  = (srow < n_x);
    assign top_in   = (srow >= CMP_W'(2));
    assign mid_in   = (srow >= CMP_W'(1));
    assign bot_in   = s1_real;
    assign col_zero = (scol == '0);

    assign cs0 = (top_in ? COLSUM_W'(s1_line_reg.line2) : '0)
               + (mid_in ? COLSUM_W'(s1_line_reg.line1) : '0)
               + (bot_in ? COLSUM_W'(s1_pix_reg) : '0);

    always_comb
    begin
        if (col_zero)
        begin
            win_sum = SUM_W'(cs1_reg) + SUM_W'(cs2_reg);
            rows3   = (srow >= CMP_W'(3)) && (srow <= n_x);
            cols3   = 1'b0;
            s1_emit = n_one || (srow >= CMP_W'(2));
        end
        else
        begin
            win_sum = SUM_W'(cs0) + SUM_W'(cs1_reg)
                    + ((scol >= CMP_W'(2)) ? SUM_W'(cs2_reg) : '0);
            rows3   = (srow >= CMP_W'(2)) && s1_real;
            cols3   = (scol >= CMP_W'(2));
            s1_emit = n_one || (srow >= CMP_W'(1));
        end
    end

    // Round half up: (s+2)/4, (s+3)/6, (s+4)/9
    assign sum_p2 = win_sum + SUM_W'(2);
    assign sum_p3 = win_sum + SUM_W'(3);
    assign sum_p4 = win_sum + SUM_W'(4);
    assign prod6  = PROD_W'(sum_p3) * PROD_W'(DIV6_MUL);
    assign prod9  = PROD_W'(sum_p4) * PROD_W'(DIV9_MUL);
    assign quot6  = prod6 >> DIV6_SHIFT;
    assign quot9  = prod9 >> DIV9_SHIFT;

    always_comb
    begin
        if (n_one)
            mean_calc = s1_pix_reg;
        else if (rows3 && cols3)
            mean_calc = quot9[PIX_W-1:0];
        else if (rows3 || cols3)
            mean_calc = quot6[PIX_W-1:0];
        else
            mean_calc = sum_p2[PIX_W+1:2];
    end

    // The last real pixel is followed by the flush, so its own result is
    // not the final one; the closing phantom carries last instead.
    assign last_flag = n_one || (srow == np1_x)
                     || (s1_real && !(srow == nm1_x && scol == nm1_x));

    always_comb
    begin
        if (s1_load)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_comb
    begin
        if (s1_go && s1_emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_RESET;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            flush_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                size_reg <= cfg_data;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            flush_reg     <= flush_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_pix_reg <= pixel;
            s1_row_reg <= row_cnt_reg;
            s1_col_reg <= col_cnt_reg;
        end
        if (s1_go)
        begin
            // Slide the column sums one column to the left
            cs1_reg <= cs0;
            cs2_reg <= cs1_reg;
        end
        if (s1_go && s1_emit)
        begin
            mean_reg    <= mean_calc;
            row_end_reg <= n_one || col_zero;
            last_reg    <= last_flag;
        end
    end

    // Line buffer read: registered, addressed by the issuing column
    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_line_reg <= line_mem[col_cnt_reg];
    end

    // Line buffer write: push the pixel down one row as the beat leaves
    always_ff @(posedge clk)
    begin
        if (s1_go && s1_real)
            line_mem[s1_col_reg] <= '{line1: s1_pix_reg, line2: s1_line_reg.line1};
    end

    assign out_valid  = out_valid_reg;
    assign mean_value = mean_reg;
    assign row_end    = row_end_reg;
    assign last       = last_reg;

`ifndef ASSERT_OFF
    // Outside a flush the next position lies inside the image
    a_pos_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        !flush_reg |-> (row_x < n_x) && (col_x < n_x))
        else $error("input position outside the image");

    // A flush only walks the two phantom rows below the image
    a_flush_rows: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> (row_x == n_x) || (row_x == np1_x))
        else $error("flush position off the phantom rows");

    // A blocked input stage keeps its position
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_row_reg)
            && $stable(s1_col_reg))
        else $error("input stage lost a blocked beat");
`endif

endmodule

`default_nettype wire

@@ bench/mean_filter_3x3_edge_shrink_test.sv @@
`timescale 1ns / 1ps

module mean_filter_3x3_edge_shrink_test;

    import mf3x3_pkg::*;

    // Idle cycles to allow after the last expected beat before a size write.
    // The window outputs trail the input by two register stages, so a few
    // spare cycles cover any beat still in flight that causes no result.
    localparam int SETTLE_CYCLES = 8;

    // Pixel beats sent under each idle mix of the random image test.
    localparam int RANDOM_BEATS_PER_MIX = 30;

    // One filtered pixel as it leaves the output channel.
    typedef struct packed {
        logic [PIX_W-1:0] mean_value;
        logic             row_end;
        logic             last_beat;
    } filtered_pixel_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [PIX_W-1:0]  pixel = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [PIX_W-1:0]  mean_value;
    logic              row_end;
    logic              last;

    // Shadow of the filter: size register, raster position and a ring of three
    // line buffers holding the most recent rows of the current image.
    logic [SIZE_W-1:0] side_reg = SIZE_RESET;
    int                row_pos = 0;
    int                col_pos = 0;
    logic [PIX_W-1:0]  line_rows [3][MAX_SIZE];

    // Filtered pixels still owed by the block, oldest first.
    filtered_pixel_t   pending_means [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    int pixels_sent = 0;
    int results_checked = 0;
    int size_writes = 0;

    mean_filter_3x3_edge_shrink uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mean_value (mean_value),
        .row_end    (row_end),
        .last       (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: stall at random at the current idle rate.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare every accepted output beat against the oldest owed pixel.
    // Sampling happens before this edge's updates land, so the values seen
    // are the ones that were present at the edge.
    always @(posedge clk)
    begin : check_filtered
        filtered_pixel_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_means.size() == 0) begin
                $error("unexpected output beat: mean_value %0d row_end %0d last %0d",
                       mean_value, row_end, last);
                error_count++;
            end
            else begin
                want = pending_means.pop_front();
                results_checked++;
                if (mean_value !== want.mean_value) begin
                    $error("mean_value mismatch: expected %0d, got %0d",
                           want.mean_value, mean_value);
                    error_count++;
                end
                if (row_end !== want.row_end) begin
                    $error("row_end mismatch: expected %0d, got %0d", want.row_end, row_end);
                    error_count++;
                end
                if (last !== want.last_beat) begin
                    $error("last mismatch: expected %0d, got %0d", want.last_beat, last);
                    error_count++;
                end
            end
        end
    end

    // Effective side: zero acts as one, anything above the buffer acts as full size.
    function automatic int image_side();
        int n;
        n = side_reg;
        if (n < 1) n = 1;
        if (n > MAX_SIZE) n = MAX_SIZE;
        return n;
    endfunction

    // Rounded mean of the clipped window around raster position q. The pixel
    // arriving at position now_pos is not yet in the line buffers.
    function automatic logic [PIX_W-1:0] window_mean(int q, int n, int now_pos,
                                                     logic [PIX_W-1:0] now_pix);
        int r;
        int c;
        int r0;
        int r1;
        int c0;
        int c1;
        int sum;
        int d;
        r = q / n;
        c = q % n;
        r0 = (r > 0) ? r - 1 : 0;
        r1 = (r + 1 < n) ? r + 1 : r;
        c0 = (c > 0) ? c - 1 : 0;
        c1 = (c + 1 < n) ? c + 1 : c;
        sum = 0;
        for (int i = r0; i <= r1; i++)
            for (int j = c0; j <= c1; j++)
                sum += (i * n + j == now_pos) ? int'(now_pix) : int'(line_rows[i % 3][j]);
        d = (r1 - r0 + 1) * (c1 - c0 + 1);
        // Round half up.
        return PIX_W'((2 * sum + d) / (2 * d));
    endfunction

    // Advance the shadow filter by one input pixel and queue what it releases.
    task automatic predict_window_means(input logic [PIX_W-1:0] pix);
        int n;
        int p;
        int first_q;
        int last_q;
        bit image_done;
        filtered_pixel_t owed;
        n = image_side();
        if (row_pos >= n || col_pos >= n) begin
            row_pos = 0;
            col_pos = 0;
        end
        p = row_pos * n + col_pos;
        image_done = (p == n * n - 1);
        first_q = 0;
        last_q = -1;
        if (image_done) begin
            // The last pixel flushes every window still open.
            first_q = (p >= n + 1) ? p - n - 1 : 0;
            last_q = p;
        end
        else if (p >= n + 1) begin
            first_q = p - n - 1;
            last_q = first_q;
        end
        for (int q = first_q; q <= last_q; q++) begin
            owed.mean_value = window_mean(q, n, p, pix);
            owed.row_end = (q % n == n - 1);
            owed.last_beat = (q == last_q);
            pending_means.push_back(owed);
        end
        line_rows[row_pos % 3][col_pos] = pix;
        if (image_done) begin
            row_pos = 0;
            col_pos = 0;
        end
        else if (col_pos + 1 >= n) begin
            col_pos = 0;
            row_pos++;
        end
        else begin
            col_pos++;
        end
    endtask

    task automatic wait_drained();
        while (pending_means.size() != 0) @(posedge clk);
    endtask

    // Send one pixel beat. Call it, or end_burst, in the same step as the
    // previous acceptance, so valid never lingers over a stale pixel.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit drain_first = 1'b0);
        if (drain_first || $urandom_range(99) < 2) begin
            in_valid <= 1'b0;
            @(posedge clk);
            wait_drained();
        end
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= pix;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pixels_sent++;
        predict_window_means(pix);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
    endtask

    // Write the side register once the filter has gone quiet; this also
    // restarts the image at the top-left pixel.
    task automatic write_image_size(input logic [SIZE_W-1:0] side);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= side;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        side_reg = side;
        row_pos = 0;
        col_pos = 0;
        size_writes++;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(int style);
        case (style)
            0: return PIX_W'($urandom_range(255));
            1: return $urandom_range(1) ? 8'hFF : 8'h00;
            2: return PIX_W'($urandom_range(255, 250));
            default: return PIX_W'($urandom_range(5));
        endcase
    endfunction

    // Reset value of the side: a partial 32-wide image, far enough in to
    // release the first few windows of the top row. Leave it unfinished;
    // the next size write restarts it.
    task automatic test_reset_side();
        for (int k = 0; k < 40; k++)
            send_pixel(pick_pixel(k % 4));
        end_burst();
    endtask

    // Tiny images with extreme pixels: pass-through, zero size, and the
    // corner, edge and interior window shapes with rounding at the half.
    task automatic test_small_extremes();
        logic [PIX_W-1:0] grid3 [9];
        grid3 = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h01};
        write_image_size(6'd1);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        end_burst();
        write_image_size(6'd0);
        send_pixel(8'hA5);
        end_burst();
        write_image_size(6'd2);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'hFE);
        end_burst();
        write_image_size(6'd3);
        for (int k = 0; k < 9; k++)
            send_pixel(grid3[k]);
        end_burst();
    endtask

    // Largest side reached through a clamped setting: the first two rows,
    // enough to release most of the top row of windows. Part way into the
    // second row, hold the sender until every owed pixel has come out.
    task automatic test_clamped_rows();
        write_image_size(6'd63);
        for (int k = 0; k < 2 * MAX_SIZE; k++)
            send_pixel(pick_pixel((k / 16) % 4), k == MAX_SIZE + MAX_SIZE / 2);
        end_burst();
    endtask

    // Random images, mostly small and complete, some back to back without a
    // size write, the final one of a group sometimes cut short so the next
    // write restarts it mid-image. Run once per idle mix.
    task automatic test_random_images();
        int sent;
        int n;
        int count;
        int groups;
        int style;
        logic [SIZE_W-1:0] side;
        for (int mix = 0; mix < 3; mix++) begin
            case (mix)
                0: begin send_idle_pct = 23; recv_idle_pct = 78; end
                1: begin send_idle_pct = 78; recv_idle_pct = 23; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            sent = 0;
            while (sent < RANDOM_BEATS_PER_MIX) begin
                if ($urandom_range(9) == 0)
                    side = SIZE_W'($urandom_range(63, 9));
                else
                    side = SIZE_W'($urandom_range(7));
                write_image_size(side);
                n = image_side();
                groups = $urandom_range(2, 1);
                for (int g = 0; g < groups; g++) begin
                    count = n * n;
                    if (g == groups - 1 && n > 1 && (n > 8 || $urandom_range(4) == 0))
                        count = $urandom_range((3 * n < n * n - 1) ? 3 * n : n * n - 1, 1);
                    // Stay within this mix's share of beats.
                    if (count > RANDOM_BEATS_PER_MIX - sent)
                        count = RANDOM_BEATS_PER_MIX - sent;
                    style = $urandom_range(3);
                    for (int k = 0; k < count; k++) begin
                        send_pixel(pick_pixel(style));
                        sent++;
                    end
                end
                end_burst();
            end
        end
    endtask

    initial
    begin
        send_idle_pct = 23;
        recv_idle_pct = 78;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_side();
        test_small_extremes();
        test_clamped_rows();
        test_random_images();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d pixels over %0d size writes (sides 0 to 63, reset side 32).",
                 pixels_sent, size_writes);
        $display("Checked %0d filtered pixels, including flushes and mid-image restarts.",
                 results_checked);
        if (error_count == 0)
            $display("mean_filter_3x3_edge_shrink regression: pass");
        else
            $display("mean_filter_3x3_edge_shrink regression: fail");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #1000000;
        $display("mean_filter_3x3_edge_shrink regression: fail");
        $finish;
    end

endmodule
